>>> src/sdds_pkg.sv
// ----------------------------------------------------------------------------
// sdds_pkg: shared definitions for the downward SCAN disk scheduler
// Widths, sequencer step codes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package sdds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_WIDTH    = 16;
	localparam int SEEK_WIDTH   = CYL_WIDTH + 1;
	// count holds 0..MAX_REQUESTS, also used as key index (head uses MAX_REQUESTS)
	localparam int CNT_WIDTH    = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_WIDTH    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int IN_TDATA_W   = ((CYL_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((CYL_WIDTH + SEEK_WIDTH + 7) / 8) * 8;

	typedef logic [CYL_WIDTH-1:0]  cyl_t;
	typedef logic [SEEK_WIDTH-1:0] seek_t;
	typedef logic [CNT_WIDTH-1:0]  cnt_t;
	typedef logic [IDX_WIDTH-1:0]  idx_t;

	// sequencer steps (microcode addresses)
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_INIT,
		ST_READ,
		ST_CMP,
		ST_DECIDE,
		ST_DONE
	} step_t;

	// branch conditions
	typedef enum logic [2:0] {
		C_NEXT,    // fall through
		C_JUMP,    // unconditional jump
		C_FINAL,   // jump when a final request is taken, else hold
		C_HEAD,    // hold until output free, jump if store empty
		C_MORE,    // jump while entries remain in the scan
		C_DECIDE   // emit/flip phase, jump back or fall through on last
	} cond_t;

	typedef struct packed {
		logic  in_rdy;   // take requests
		logic  head;     // emit head start
		logic  init;     // clear scan index and best
		logic  rd;       // read store at scan index
		logic  cmp;      // compare read entry against best
		logic  decide;   // emit best or turn the head
		logic  clr;      // drop queued requests
		cond_t cond;
		step_t target;
	} ctrl_t;

	// microcode ROM
	function automatic ctrl_t ucode(step_t s);
		ctrl_t cw;
		cw = '{in_rdy: 1'b0, head: 1'b0, init: 1'b0, rd: 1'b0, cmp: 1'b0,
		       decide: 1'b0, clr: 1'b0, cond: C_JUMP, target: ST_IDLE};
		case (s)
			ST_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond   = C_FINAL;
				cw.target = ST_HEAD;
			end
			ST_HEAD: begin
				cw.head   = 1'b1;
				cw.cond   = C_HEAD;
				cw.target = ST_DONE;
			end
			ST_INIT: begin
				cw.init = 1'b1;
				cw.cond = C_NEXT;
			end
			ST_READ: begin
				cw.rd   = 1'b1;
				cw.cond = C_NEXT;
			end
			ST_CMP: begin
				cw.cmp    = 1'b1;
				cw.cond   = C_MORE;
				cw.target = ST_READ;
			end
			ST_DECIDE: begin
				cw.decide = 1'b1;
				cw.cond   = C_DECIDE;
				cw.target = ST_INIT;
			end
			ST_DONE: begin
				cw.clr    = 1'b1;
				cw.cond   = C_JUMP;
				cw.target = ST_IDLE;
			end
			default: begin
				cw.cond   = C_JUMP;
				cw.target = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

>>> src/scan_down_disk_schedule.sv
// ----------------------------------------------------------------------------
// scan_down_disk_schedule: SCAN (elevator) disk scheduler, downward first
// Queues cylinder requests, then emits the head start, the requests at or
// below it in descending order, then those above it in ascending order,
// each with the running sum of head movement.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: cylinder; s_tlast: final_request
//  m_*      | out | m_tvalid/m_tready  | m_tdata: visited_cylinder, running_seek;
//           |     |                    | m_tlast: last_visit
//  cfg_*    | in  | cfg_we             | cfg_wdata: head_start
//
//  Requests load at one per cycle while the sequencer sits in its idle step.
//  A schedule runs one head step, one selection scan per request visit over
//  the request store (init, a read and a compare step per entry through its
//  single read port, then decide), one extra scan where the head turns, and
//  one clear step.
//  Reset clears the step counter, the request count, head_start and the
//  output valid; the store is not cleared. A stalled output holds the
//  sequencer in a step that emits; no requests are taken during a schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_down_disk_schedule (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration: head_start
	input  wire                                 cfg_we,
	input  wire [sdds_pkg::CYL_WIDTH-1:0]       cfg_wdata,
	// request stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [sdds_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] cylinder
	input  wire                                 s_tlast,   // final_request
	// visit stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [sdds_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [15:0] visited_cylinder,
	                                                       // [32:16] running_seek
	output logic                                m_tlast    // last_visit
);
	import sdds_pkg::*;

	// sequencer
	step_t  step_q, step_d;
	ctrl_t  cw;

	// datapath state
	cyl_t   head_q;
	cnt_t   count_q;
	cyl_t   mem [MAX_REQUESTS];
	cyl_t   rd_q;
	cnt_t   idx_q;
	cnt_t   k_q;
	logic   found_q;
	cyl_t   best_c_q;
	cnt_t   best_i_q;
	cyl_t   prev_c_q;
	cnt_t   prev_i_q;
	logic   up_q;
	logic   up_seen_q;
	seek_t  seek_q;

	// output register
	logic   m_tvalid_q;
	cyl_t   out_cyl_q;
	seek_t  out_seek_q;
	logic   out_last_q;

	logic   accept, out_free, head_fire, dec_fire, last_sel, more, cand, better;
	cyl_t   travel;
	seek_t  seek_nxt;
	logic [CYL_WIDTH+CNT_WIDTH-1:0] ent_key, best_key, prev_key;

	assign cw       = ucode(step_q);
	assign s_tready = cw.in_rdy;
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign more      = (idx_q + cnt_t'(1)) < count_q;
	assign last_sel  = (k_q + cnt_t'(1)) == count_q;
	assign head_fire = cw.head && out_free;
	assign dec_fire  = cw.decide && found_q && out_free;

	// selection keys: value first, store index breaks ties
	assign ent_key  = {rd_q, idx_q};
	assign best_key = {best_c_q, best_i_q};
	assign prev_key = {prev_c_q, prev_i_q};

	// candidate and improvement test for the entry being scanned
	always_comb begin
		if (!up_q) begin
			cand   = (rd_q <= head_q) && (ent_key < prev_key);
			better = !found_q || (ent_key > best_key);
		end else begin
			cand   = (rd_q > head_q) && (!up_seen_q || (ent_key > prev_key));
			better = !found_q || (ent_key < best_key);
		end
	end

	// movement to the selected cylinder
	assign travel   = (best_c_q >= prev_c_q) ? (best_c_q - prev_c_q) : (prev_c_q - best_c_q);
	assign seek_nxt = seek_q + SEEK_WIDTH'(travel);

	// next step
	always_comb begin
		step_d = step_q;
		case (cw.cond)
			C_NEXT:  step_d = step_t'(step_q + 3'd1);
			C_JUMP:  step_d = cw.target;
			C_FINAL: begin
				if (accept && s_tlast) step_d = cw.target;
			end
			C_HEAD: begin
				if (out_free) step_d = (count_q == '0) ? cw.target : step_t'(step_q + 3'd1);
			end
			C_MORE:  step_d = more ? cw.target : step_t'(step_q + 3'd1);
			C_DECIDE: begin
				if (!found_q) begin
					step_d = cw.target;
				end else if (out_free) begin
					step_d = last_sel ? step_t'(step_q + 3'd1) : cw.target;
				end
			end
			default: step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= ST_IDLE;
		else         step_q <= step_d;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     head_q <= '0;
		else if (cfg_we) head_q <= cfg_wdata;
	end

	// request count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cw.clr) begin
			count_q <= '0;
		end else if (accept && (count_q < cnt_t'(MAX_REQUESTS))) begin
			count_q <= count_q + cnt_t'(1);
		end
	end

	// request store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && (count_q < cnt_t'(MAX_REQUESTS)))
			mem[count_q[IDX_WIDTH-1:0]] <= s_tdata[CYL_WIDTH-1:0];
		if (cw.rd)
			rd_q <= mem[idx_q[IDX_WIDTH-1:0]];
	end

	// scan and phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			up_q      <= 1'b0;
			up_seen_q <= 1'b0;
			idx_q     <= '0;
			k_q       <= '0;
		end else begin
			if (head_fire) begin
				up_q      <= 1'b0;
				up_seen_q <= 1'b0;
				k_q       <= '0;
			end
			if (cw.init) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cw.cmp) begin
				idx_q <= idx_q + cnt_t'(1);
				if (cand && better) found_q <= 1'b1;
			end
			if (cw.decide && !found_q) begin
				// nothing left below the head: turn upward
				up_q      <= 1'b1;
				up_seen_q <= 1'b0;
			end
			if (dec_fire) begin
				k_q <= k_q + cnt_t'(1);
				if (up_q) up_seen_q <= 1'b1;
			end
		end
	end

	// best candidate, previous visit and running seek
	always_ff @(posedge clk) begin
		if (cw.cmp && cand && better) begin
			best_c_q <= rd_q;
			best_i_q <= idx_q;
		end
		if (head_fire) begin
			prev_c_q <= head_q;
			prev_i_q <= cnt_t'(MAX_REQUESTS);
			seek_q   <= '0;
		end
		if (dec_fire) begin
			prev_c_q <= best_c_q;
			prev_i_q <= best_i_q;
			seek_q   <= seek_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (head_fire || dec_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_fire) begin
			out_cyl_q  <= head_q;
			out_seek_q <= '0;
			out_last_q <= (count_q == '0);
		end else if (dec_fire) begin
			out_cyl_q  <= best_c_q;
			out_seek_q <= seek_nxt;
			out_last_q <= last_sel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_TDATA_W'({out_seek_q, out_cyl_q});

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_REQUESTS))
		else $error("request count above capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cw.cmp |-> (idx_q < count_q))
		else $error("scan read past queued requests");

	a_down_below_head: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_fire && !up_q) |-> (best_c_q <= head_q))
		else $error("downward visit above head start");

	a_up_above_head: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_fire && up_q) |-> (best_c_q > head_q))
		else $error("upward visit at or below head start");

endmodule

`default_nettype wire

>>> test/tb_scan_down_disk_schedule.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scan_down_disk_schedule: self-checking bench for the downward SCAN scheduler
// Loads batches of cylinder requests under several head_start settings and
// idle mixes. A scoreboard predicts each visit sequence and running seek
// total, then checks every visit the block emits, in order.
// ----------------------------------------------------------------------------

module tb_scan_down_disk_schedule;
	import sdds_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		cyl_t  cyl;
		seek_t seek;
		logic  last;
	} visit_t;

	// scoreboard: queued requests, predicted visits, error count
	class visit_board;
		cyl_t        head;
		cyl_t        queued[$];
		visit_t      due_visits[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned dropped;
		int unsigned schedules;
		int unsigned visits;

		function new();
			head      = '0;
			errors    = 0;
			requests  = 0;
			dropped   = 0;
			schedules = 0;
			visits    = 0;
		endfunction

		// service rank: at or below head by falling value, then above by rising value
		function int unsigned order_key(cyl_t v);
			return (v <= head) ? 32'(head - v) : 32'h10000 + 32'(v);
		endfunction

		function void note_request(cyl_t c, logic fin);
			cyl_t  route[MAX_REQUESTS+1];
			int    n;
			int    j;
			seek_t seek;
			cyl_t  prev;
			requests++;
			if (queued.size() < MAX_REQUESTS)
				queued.insert(queued.size(), c);
			else
				dropped++;
			if (!fin)
				return;
			// head start joins the requests; insertion sort by service rank
			route[0] = head;
			n = 1;
			foreach (queued[i]) begin
				j = n;
				while (j > 0 && order_key(route[j-1]) > order_key(queued[i])) begin
					route[j] = route[j-1];
					j--;
				end
				route[j] = queued[i];
				n++;
			end
			seek = '0;
			prev = head;
			for (int i = 0; i < n; i++) begin
				seek = seek + seek_t'((route[i] >= prev) ? route[i] - prev : prev - route[i]);
				prev = route[i];
				due_visits.insert(due_visits.size(),
					visit_t'{cyl: route[i], seek: seek, last: (i == n - 1)});
			end
			queued.delete();
			schedules++;
		endfunction

		function void check_visit(cyl_t cyl, seek_t seek, logic last);
			visit_t want;
			visits++;
			if (due_visits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected visit cyl %0d seek %0d last %0b",
						$time, cyl, seek, last);
				return;
			end
			want = due_visits.pop_front();
			if (want.cyl !== cyl || want.seek !== seek || want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: visit mismatch: expected cyl %0d seek %0d last %0b,",
						" got cyl %0d seek %0d last %0b"},
						$time, want.cyl, want.seek, want.last, cyl, seek, last);
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	cyl_t                   cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;    // [15:0] cylinder
	logic                   s_tlast   = 1'b0;  // final_request
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;           // [15:0] visited_cylinder, [32:16] running_seek
	logic                   m_tlast;           // last_visit

	visit_board  board;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct  = 0;
	int unsigned quiet_cycles    = 0;

	scan_down_disk_schedule dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor both streams, watchdog on stalled traffic
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_request(s_tdata[CYL_WIDTH-1:0], s_tlast);
			if (m_tvalid && m_tready)
				board.check_visit(m_tdata[CYL_WIDTH-1:0], m_tdata[CYL_WIDTH +: SEEK_WIDTH],
					m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles, %0d visits outstanding",
					quiet_cycles, board.due_visits.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// one request, with optional sender gaps before it
	task automatic send_request(cyl_t c, logic fin);
		if (sender_idle_pct != 0) begin
			while ($urandom_range(99) < sender_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(c);
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every predicted visit has arrived and the block is idle
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.due_visits.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_head(cyl_t h);
		cfg_we    <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.head = h;
	endtask

	// random batches; values cluster near the head to exercise the turn point
	task automatic run_phase(bit overflow_first);
		int   sent;
		int   len;
		int   near;
		cyl_t c;
		cyl_t prev_c;
		sent   = 0;
		prev_c = board.head;
		while (sent < 62) begin
			if (overflow_first && sent == 0)
				len = 36;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(33, 9);
			else
				len = $urandom_range(8, 1);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: c = cyl_t'($urandom);
					4, 5, 6: begin
						near = int'(board.head) + int'($urandom_range(64)) - 32;
						if (near < 0)
							near = 0;
						if (near > 65535)
							near = 65535;
						c = cyl_t'(near);
					end
					7: c = prev_c;
					8: c = $urandom_range(1) ? '1 : '0;
					default: c = board.head;
				endcase
				send_request(c, k == len - 1);
				prev_c = c;
			end
			sent += len;
			// sometimes let the whole schedule drain before the next batch
			if ($urandom_range(3) == 0)
				settle();
		end
	endtask

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, equal values, head at both ends, single request
		write_head('0);
		send_request('0, 1'b1);
		send_request('1, 1'b0);
		send_request('0, 1'b0);
		send_request('1, 1'b1);
		settle();
		write_head('1);
		send_request('1, 1'b0);
		send_request('0, 1'b0);
		send_request(16'd1, 1'b1);
		send_request(16'd40000, 1'b1);
		settle();
		write_head(16'd1000);
		send_request(16'd1000, 1'b0);
		send_request(16'd999, 1'b0);
		send_request(16'd1001, 1'b0);
		send_request(16'd1000, 1'b0);
		send_request('0, 1'b0);
		send_request('1, 1'b1);

		// random phases over head settings and idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
					write_head('0);
				end
				1: begin
					sender_idle_pct = 63;
					recv_stall_pct  = 0;
					write_head('1);
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 63;
					write_head(cyl_t'($urandom));
				end
				default: begin
					sender_idle_pct = 36;
					recv_stall_pct  = 36;
					write_head(16'd32768);
				end
			endcase
			run_phase(ph == 0);
		end

		settle();
		repeat (32) @(posedge clk);
		$display("Covered %0d requests (%0d dropped on a full store), %0d schedules, %0d visits",
			board.requests, board.dropped, board.schedules, board.visits);
		$display("Head settings at both ends and in between, under four idle/stall mixes");
		if (board.errors == 0 && board.due_visits.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d visits never arrived",
				board.errors, board.due_visits.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
